// ----- src/mtgp_pkg.sv -----
// shared types, constants and the label name table for the teleinfo group parser
// no dependencies; used by mtgp_group_core and meter_teleinfo_group_parser
`timescale 1ns / 1ps

package mtgp_pkg;

	localparam int MAX_LABEL_CHARS = 8;
	localparam int MAX_TEXT_CHARS  = 8;
	localparam int NAME_COUNT      = 12;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_STX = 8'h02;
	localparam logic [7:0] CH_ETX = 8'h03;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_D0  = 8'h30;
	localparam logic [7:0] CH_D9  = 8'h39;

	localparam logic [39:0] NUM_SAT = 40'd999999999999;

	// label count value that marks a label too long to ever match
	localparam logic [3:0] LABEL_OVER = 4'(MAX_LABEL_CHARS + 1);

	// names packed with the first character in the top byte, zero padded
	localparam logic [63:0] NAME_WORDS [NAME_COUNT] = '{
		{"ADCO", 32'h0},
		{"OPTARIF", 8'h0},
		{"ISOUSC", 16'h0},
		{"BASE", 32'h0},
		{"HCHC", 32'h0},
		{"HCHP", 32'h0},
		{"PTEC", 32'h0},
		{"IINST", 24'h0},
		{"IMAX", 32'h0},
		{"PAPP", 32'h0},
		{"HHPHC", 24'h0},
		{"MOTDETAT"}
	};

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_LABEL = 4'b0010,
		PH_DATA  = 4'b0100,
		PH_CSUM  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [3:0]  field_code;
		logic [39:0] numeric_value;
		logic [63:0] text_value;
		logic [3:0]  text_length;
	} result_t;

	// one finished group leaving the parser core
	typedef struct packed {
		logic    valid;
		result_t data;
	} result_msg_t;

endpackage

// ----- src/mtgp_group_core.sv -----
// per-byte group parser state: transmission, phase, label, number and text
// depends on mtgp_pkg
`timescale 1ns / 1ps

module mtgp_group_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_en,
	input  logic [7:0]           rx_byte,
	output mtgp_pkg::result_msg_t result
);
	import mtgp_pkg::*;

	logic        in_tx_q;
	phase_t      phase_q;
	logic [63:0] label_q;
	logic [3:0]  label_cnt_q;
	logic        label_closed_q;
	logic [39:0] num_q;
	logic        num_closed_q;
	logic [63:0] text_q;
	logic [3:0]  text_cnt_q;
	logic        text_closed_q;

	logic        in_tx_d;
	phase_t      phase_d;
	logic [63:0] label_d;
	logic [3:0]  label_cnt_d;
	logic        label_closed_d;
	logic [39:0] num_d;
	logic        num_closed_d;
	logic [63:0] text_d;
	logic [3:0]  text_cnt_d;
	logic        text_closed_d;

	logic [7:0]  b;
	logic        is_digit;
	logic [43:0] num_wide;
	logic [2:0]  label_slot;
	logic [2:0]  text_slot;
	logic        name_hit;
	logic [3:0]  name_code;

	// bytes above 127 read as nul
	assign b        = rx_byte[7] ? CH_NUL : rx_byte;
	assign is_digit = (b >= CH_D0) && (b <= CH_D9);

	// accum * 10 + digit, wide enough to never wrap before the saturation check
	assign num_wide = ({4'b0, num_q} << 3) + ({4'b0, num_q} << 1)
		+ {40'b0, b[3:0]};

	assign label_slot = 3'd7 - label_cnt_q[2:0];
	assign text_slot  = 3'd7 - text_cnt_q[2:0];

	always_comb begin
		name_hit  = 1'b0;
		name_code = '0;
		for (int k = 0; k < NAME_COUNT; k++) begin
			if (!name_hit && label_q == NAME_WORDS[k]) begin
				name_hit  = 1'b1;
				name_code = 4'(k);
			end
		end
		if (label_cnt_q == 4'd0 || label_cnt_q > 4'(MAX_LABEL_CHARS))
			name_hit = 1'b0;
	end

	always_comb begin
		in_tx_d        = in_tx_q;
		phase_d        = phase_q;
		label_d        = label_q;
		label_cnt_d    = label_cnt_q;
		label_closed_d = label_closed_q;
		num_d          = num_q;
		num_closed_d   = num_closed_q;
		text_d         = text_q;
		text_cnt_d     = text_cnt_q;
		text_closed_d  = text_closed_q;

		result.valid              = 1'b0;
		result.data.field_code    = name_code;
		result.data.numeric_value = num_q;
		result.data.text_value    = text_q;
		result.data.text_length   = text_cnt_q;

		if (byte_en) begin
			if (b == CH_STX || (in_tx_q && (b == CH_ETX || b == CH_LF || b == CH_CR))) begin
				// group boundary: drop whatever was collected
				label_d        = '0;
				label_cnt_d    = '0;
				label_closed_d = 1'b0;
				num_d          = '0;
				num_closed_d   = 1'b0;
				text_d         = '0;
				text_cnt_d     = '0;
				text_closed_d  = 1'b0;
				phase_d        = (b == CH_LF) ? PH_LABEL : PH_IDLE;
				if (b == CH_STX)
					in_tx_d = 1'b1;
				else if (b == CH_ETX)
					in_tx_d = 1'b0;
				if (b == CH_CR && phase_q == PH_CSUM && name_hit)
					result.valid = 1'b1;
			end else if (in_tx_q) begin
				unique case (phase_q)
					PH_LABEL: begin
						if (b == CH_SP) begin
							phase_d = PH_DATA;
						end else if (!label_closed_q) begin
							if (b == CH_NUL)
								label_closed_d = 1'b1;
							else if (label_cnt_q < 4'(MAX_LABEL_CHARS)) begin
								label_d[8*label_slot +: 8] = b;
								label_cnt_d = label_cnt_q + 4'd1;
							end else
								label_cnt_d = LABEL_OVER;
						end
					end
					PH_DATA: begin
						if (b == CH_SP) begin
							phase_d = PH_CSUM;
						end else if (b == CH_NUL) begin
							num_closed_d  = 1'b1;
							text_closed_d = 1'b1;
						end else begin
							if (!num_closed_q) begin
								if (is_digit)
									num_d = (num_wide > {4'b0, NUM_SAT}) ? NUM_SAT
										: num_wide[39:0];
								else
									num_closed_d = 1'b1;
							end
							if (!text_closed_q && text_cnt_q < 4'(MAX_TEXT_CHARS)) begin
								text_d[8*text_slot +: 8] = b;
								text_cnt_d = text_cnt_q + 4'd1;
							end
						end
					end
					PH_IDLE, PH_CSUM: begin
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tx_q        <= 1'b0;
			phase_q        <= PH_IDLE;
			label_q        <= '0;
			label_cnt_q    <= '0;
			label_closed_q <= 1'b0;
			num_q          <= '0;
			num_closed_q   <= 1'b0;
			text_q         <= '0;
			text_cnt_q     <= '0;
			text_closed_q  <= 1'b0;
		end else begin
			in_tx_q        <= in_tx_d;
			phase_q        <= phase_d;
			label_q        <= label_d;
			label_cnt_q    <= label_cnt_d;
			label_closed_q <= label_closed_d;
			num_q          <= num_d;
			num_closed_q   <= num_closed_d;
			text_q         <= text_d;
			text_cnt_q     <= text_cnt_d;
			text_closed_q  <= text_closed_d;
		end
	end

endmodule

// ----- src/meter_teleinfo_group_parser.sv -----
// top level of the historic-mode meter teleinfo group parser with output buffering
// depends on mtgp_pkg and mtgp_group_core
`timescale 1ns / 1ps

// Takes the meter serial link one byte per stream transaction and gives one
// result transaction for each complete group (LF label SP data SP checksum CR)
// whose label is one of the twelve known names, inside an STX..ETX
// transmission. A byte is taken every clock cycle while s_axis_tready is high: the
// whole per-byte update (label capture, decimal step with saturation at twelve
// digits, text capture, name lookup at CR) is one level of logic on the parser
// state registers, and a result is registered as its CR is taken. The output
// side holds an output register plus one skid entry, so input keeps flowing
// while a result waits; s_axis_tready drops only when both are full, i.e. when
// the skid entry is occupied. The checksum field is not checked.
module meter_teleinfo_group_parser (
	input  logic          clk,
	input  logic          arst_n,
	// input stream
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [7:0]    s_axis_tdata,  // [7:0] rx_byte
	// result stream
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [111:0]  m_axis_tdata   // [3:0] field_code, [43:4] numeric_value,
	                                     // [107:44] text_value, [111:108] text_length
);
	import mtgp_pkg::*;

	logic        in_accept;
	logic        out_pop;
	result_msg_t core_res;

	result_t     out_q;
	logic        out_vld_q;
	result_t     skid_q;
	logic        skid_vld_q;

	// input transaction: one byte into the parser
	assign s_axis_tready = !skid_vld_q;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign out_pop       = out_vld_q && m_axis_tready;

	mtgp_group_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_en (in_accept),
		.rx_byte (s_axis_tdata),
		.result  (core_res)
	);

	// control: output register valid and skid entry valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			// no new results while the skid entry is full
			if (out_pop)
				skid_vld_q <= 1'b0;
		end else if (core_res.valid) begin
			if (out_vld_q && !out_pop)
				skid_vld_q <= 1'b1;
			else
				out_vld_q <= 1'b1;
		end else if (out_pop) begin
			out_vld_q <= 1'b0;
		end
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_pop)
				out_q <= skid_q;
		end else if (core_res.valid) begin
			if (out_vld_q && !out_pop)
				skid_q <= core_res.data;
			else
				out_q <= core_res.data;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {out_q.text_length, out_q.text_value,
		out_q.numeric_value, out_q.field_code};

endmodule

// ----- bench/tb_meter_teleinfo_group_parser.sv -----
// self-checking bench for meter_teleinfo_group_parser: byte stream in, decoded groups out
// depends on mtgp_pkg and the parser rtl; predicts each group from the bytes it accepts
`timescale 1ns / 1ps

module tb_meter_teleinfo_group_parser;
	import mtgp_pkg::*;

	typedef enum logic [3:0] {
		FC_ADCO, FC_OPTARIF, FC_ISOUSC, FC_BASE, FC_HCHC, FC_HCHP,
		FC_PTEC, FC_IINST, FC_IMAX, FC_PAPP, FC_HHPHC, FC_MOTDETAT
	} field_code_e;

	typedef enum logic [1:0] {
		GRP_NONE, GRP_LABEL, GRP_DATA, GRP_CSUM
	} group_phase_e;

	localparam int LABEL_KINDS  = FC_MOTDETAT + 1;
	localparam int DRAIN_CYCLES = 32;

	// label words indexed by field code, first character in the top byte
	localparam logic [63:0] KNOWN_LABELS [LABEL_KINDS] = '{
		{"ADCO", 32'h0}, {"OPTARIF", 8'h0}, {"ISOUSC", 16'h0}, {"BASE", 32'h0},
		{"HCHC", 32'h0}, {"HCHP", 32'h0}, {"PTEC", 32'h0}, {"IINST", 24'h0},
		{"IMAX", 32'h0}, {"PAPP", 32'h0}, {"HHPHC", 24'h0}, {"MOTDETAT"}
	};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = 8'h00;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [111:0] m_axis_tdata;

	bit      no_stall = 1'b0;
	int      mismatch_count = 0;
	int      bytes_sent = 0;
	result_t decoded_groups [$];

	// parser state as the bench sees it
	bit              in_frame = 1'b0;
	group_phase_e    phase = GRP_NONE;
	logic [63:0]     label_word = '0;
	int              label_len = 0;
	bit              label_shut = 1'b0;
	longint unsigned number = 0;
	bit              number_shut = 1'b0;
	logic [63:0]     text_word = '0;
	int              text_len = 0;
	bit              text_shut = 1'b0;

	meter_teleinfo_group_parser uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #10 clk = ~clk;

	function automatic void clear_group();
		label_word = '0;
		label_len = 0;
		label_shut = 1'b0;
		number = 0;
		number_shut = 1'b0;
		text_word = '0;
		text_len = 0;
		text_shut = 1'b0;
	endfunction

	// advance the bench copy of the parser by one accepted byte
	function automatic void parse_rx_byte(input logic [7:0] rx);
		logic [7:0] ch;
		result_t    res;
		bit         hit;
		ch = rx[7] ? CH_NUL : rx;
		hit = 1'b0;
		res = '0;
		if (ch == CH_STX) begin
			in_frame = 1'b1;
			phase = GRP_NONE;
			clear_group();
		end else if (in_frame) begin
			if (ch == CH_ETX) begin
				in_frame = 1'b0;
				phase = GRP_NONE;
				clear_group();
			end else if (ch == CH_LF) begin
				clear_group();
				phase = GRP_LABEL;
			end else if (ch == CH_CR) begin
				if (phase == GRP_CSUM && label_len >= 1 && label_len <= MAX_LABEL_CHARS) begin
					for (int k = 0; k < LABEL_KINDS; k++) begin
						if (!hit && KNOWN_LABELS[k] == label_word) begin
							hit = 1'b1;
							res.field_code = field_code_e'(k);
						end
					end
				end
				if (hit) begin
					res.numeric_value = 40'(number);
					res.text_value = text_word;
					res.text_length = 4'(text_len);
					decoded_groups.push_back(res);
				end
				phase = GRP_NONE;
				clear_group();
			end else begin
				case (phase)
				GRP_LABEL: begin
					if (ch == CH_SP) begin
						phase = GRP_DATA;
					end else if (!label_shut) begin
						if (ch == CH_NUL) begin
							label_shut = 1'b1;
						end else if (label_len < MAX_LABEL_CHARS) begin
							label_word[63 - 8 * label_len -: 8] = ch;
							label_len++;
						end else begin
							label_len = LABEL_OVER;
						end
					end
				end
				GRP_DATA: begin
					if (ch == CH_SP) begin
						phase = GRP_CSUM;
					end else if (ch == CH_NUL) begin
						number_shut = 1'b1;
						text_shut = 1'b1;
					end else begin
						if (!number_shut) begin
							if (ch >= CH_D0 && ch <= CH_D9) begin
								number = number * 10 + (ch - CH_D0);
								if (number > NUM_SAT) begin
									number = NUM_SAT;
								end
							end else begin
								number_shut = 1'b1;
							end
						end
						if (!text_shut && text_len < MAX_TEXT_CHARS) begin
							text_word[63 - 8 * text_len -: 8] = ch;
							text_len++;
						end
					end
				end
				default: ;
				endcase
			end
		end
	endfunction

	// one byte transaction on the input side, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b);
		while (!no_stall && $urandom_range(0, 99) < 8) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		parse_rx_byte(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i]);
		end
	endtask

	// well-formed group: lf label sp data sp checksum cr
	task automatic send_group(input string label, input string data, input string csum);
		send_byte(CH_LF);
		send_text(label);
		send_byte(CH_SP);
		send_text(data);
		send_byte(CH_SP);
		send_text(csum);
		send_byte(CH_CR);
	endtask

	// drop valid and wait until every decoded group has left the block
	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		do begin
			@(posedge clk);
		end while (decoded_groups.size() != 0);
	endtask

	// mostly well-formed groups with random content, some framing churn and noise
	task automatic send_random_group();
		int          kind;
		int          pick;
		int          n;
		bit          all_digits;
		logic [7:0]  ch;
		logic [63:0] name;
		kind = $urandom_range(0, 99);
		if (kind < 6) begin
			// close the transmission, junk in between, reopen
			send_byte(CH_ETX);
			n = $urandom_range(0, 3);
			repeat (n) send_byte(8'($urandom_range(0, 255)));
			send_byte(CH_STX);
		end else if (kind < 14) begin
			n = $urandom_range(1, 4);
			repeat (n) send_byte(8'($urandom_range(0, 255)));
		end else begin
			send_byte(CH_LF);
			if ($urandom_range(0, 99) < 85) begin
				name = KNOWN_LABELS[$urandom_range(0, LABEL_KINDS - 1)];
				for (int i = 0; i < 8; i++) begin
					if (name[63 - 8 * i -: 8] != CH_NUL) begin
						send_byte(name[63 - 8 * i -: 8]);
					end
				end
				// occasionally one letter too many
				if ($urandom_range(0, 99) < 5) begin
					send_byte(8'($urandom_range(8'h41, 8'h5A)));
				end
			end else begin
				n = $urandom_range(0, 10);
				repeat (n) begin
					if ($urandom_range(0, 9) == 0) begin
						send_byte(8'($urandom_range(0, 255)));
					end else begin
						send_byte(8'($urandom_range(8'h41, 8'h5A)));
					end
				end
			end
			if ($urandom_range(0, 99) < 3) begin
				send_byte(CH_CR);
				return;
			end
			send_byte(CH_SP);
			all_digits = ($urandom_range(0, 99) < 10);
			n = all_digits ? $urandom_range(10, 16) : $urandom_range(0, 10);
			repeat (n) begin
				pick = $urandom_range(0, 99);
				if (all_digits || pick < 70) begin
					ch = CH_D0 + 8'($urandom_range(0, 9));
				end else if (pick < 85) begin
					ch = 8'($urandom_range(8'h21, 8'h7E));
				end else if (pick < 93) begin
					ch = 8'($urandom_range(8'h80, 8'hFF));
				end else if (pick < 96) begin
					ch = CH_NUL;
				end else begin
					ch = 8'($urandom_range(0, 255));
				end
				send_byte(ch);
			end
			if ($urandom_range(0, 99) < 4) begin
				send_byte(CH_CR);
				return;
			end
			send_byte(CH_SP);
			n = $urandom_range(0, 3);
			repeat (n) send_byte(8'($urandom_range(CH_SP, 8'h7E)));
			send_byte(CH_CR);
		end
	endtask

	// bytes before stx are ignored, the same group inside a transmission decodes
	task automatic test_outside_frame();
		send_byte(8'h41);
		send_group("BASE", "5", "X");
		send_byte(8'hFF);
		send_byte(CH_ETX);
		send_byte(CH_STX);
		send_group("BASE", "5", "X");
	endtask

	// saturation at twelve digits, text cut at eight, leading zeros, non-digit start
	task automatic test_numeric_extremes();
		send_group("HCHC", "9999999999999", "A");
		send_group("MOTDETAT", "000000", "");
		send_group("ADCO", "X12", "");
		send_group("OPTARIF", "BASE", "");
	endtask

	// high bytes and literal zero act as nul and close the field
	task automatic test_nul_handling();
		send_byte(CH_LF);
		send_text("IINST");
		send_byte(CH_SP);
		send_text("12");
		send_byte(8'h80);
		send_text("3");
		send_byte(CH_SP);
		send_byte(CH_CR);
		// nul inside the label, later label bytes ignored
		send_byte(CH_LF);
		send_text("PAPP");
		send_byte(CH_NUL);
		send_text("Q");
		send_byte(CH_SP);
		send_text("7");
		send_byte(8'hFF);
		send_byte(CH_SP);
		send_byte(CH_CR);
		// the del byte and a control byte as data
		send_byte(CH_LF);
		send_text("IMAX");
		send_byte(CH_SP);
		send_byte(8'h7F);
		send_byte(8'h01);
		send_byte(CH_SP);
		send_byte(CH_CR);
	endtask

	// groups that are cut short, restarted or carry a label that cannot match
	task automatic test_dropped_groups();
		// cr before the second space
		send_byte(CH_LF);
		send_text("HCHP 1");
		send_byte(CH_CR);
		// lf inside a group restarts it
		send_byte(CH_LF);
		send_text("PTEC");
		send_group("PTEC", "HP..", "");
		send_group("XYZ", "1", "");
		send_group("", "1", "");
		send_group("MOTDETATS", "1", "");
		// further spaces belong to the checksum
		send_group("ISOUSC", "30", " C ");
		// etx in the middle of a group, then a group outside any transmission
		send_byte(CH_LF);
		send_text("HHPHC A");
		send_byte(CH_ETX);
		send_group("BASE", "1", "");
		send_byte(CH_STX);
		// stx in the middle of a group
		send_byte(CH_LF);
		send_text("BASE 1");
		send_byte(CH_STX);
		send_text(" X");
		send_byte(CH_CR);
		send_group("HHPHC", "A", "");
	endtask

	task automatic test_random_traffic(input int items);
		int stop_at;
		stop_at = bytes_sent + items;
		while (bytes_sent < stop_at) begin
			send_random_group();
		end
	endtask

	// long run with both sides always ready
	task automatic test_back_to_back(input int items);
		no_stall <= 1'b1;
		test_random_traffic(items);
		no_stall <= 1'b0;
	endtask

	// sender stops until the output side has emptied, several times
	task automatic test_drain_pauses();
		repeat (4) begin
			repeat (3) send_random_group();
			hold_until_drained();
		end
	endtask

	// result side stalls at random, about 8 percent of the time, unless no_stall is set
	always @(posedge clk) begin
		m_axis_tready <= no_stall || ($urandom_range(0, 99) >= 8);
	end

	// each result transaction against the oldest decoded group
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (decoded_groups.size() == 0) begin
				$error("result with nothing expected: %h", m_axis_tdata);
				mismatch_count++;
			end else begin
				want = decoded_groups.pop_front();
				if (m_axis_tdata[3:0] !== want.field_code) begin
					$error("field_code: expected %0d, got %0d",
						want.field_code, m_axis_tdata[3:0]);
					mismatch_count++;
				end
				if (m_axis_tdata[43:4] !== want.numeric_value) begin
					$error("numeric_value: expected %0d, got %0d",
						want.numeric_value, m_axis_tdata[43:4]);
					mismatch_count++;
				end
				if (m_axis_tdata[107:44] !== want.text_value) begin
					$error("text_value: expected %h, got %h",
						want.text_value, m_axis_tdata[107:44]);
					mismatch_count++;
				end
				if (m_axis_tdata[111:108] !== want.text_length) begin
					$error("text_length: expected %0d, got %0d",
						want.text_length, m_axis_tdata[111:108]);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_outside_frame();
		test_numeric_extremes();
		test_nul_handling();
		test_dropped_groups();
		test_random_traffic(650);
		test_back_to_back(300);
		test_drain_pauses();
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// watchdog, far above the slowest legal run
	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

// ----- meter_teleinfo_group_parser.f -----
src/mtgp_pkg.sv
src/mtgp_group_core.sv
src/meter_teleinfo_group_parser.sv
bench/tb_meter_teleinfo_group_parser.sv
